// ----- hw/rtl/gdrc_pkg.sv -----
// Shared types and constants of the grid DDA column ray caster.
package gdrc_pkg;

   // Register map
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_CAM_X    = 3'd0;
   localparam logic [2:0] REG_CAM_Y    = 3'd1;
   localparam logic [2:0] REG_DIR_X    = 3'd2;
   localparam logic [2:0] REG_DIR_Y    = 3'd3;
   localparam logic [2:0] REG_PLANE_X  = 3'd4;
   localparam logic [2:0] REG_PLANE_Y  = 3'd5;
   localparam logic [2:0] REG_SCREEN_W = 3'd6;
   localparam logic [2:0] REG_SCREEN_H = 3'd7;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   // Wall faces
   localparam logic [1:0] FACE_NORTH = 2'd0;
   localparam logic [1:0] FACE_SOUTH = 2'd1;
   localparam logic [1:0] FACE_EAST  = 2'd2;
   localparam logic [1:0] FACE_WEST  = 2'd3;

   // Datapath widths
   localparam int CX_W = 26;   // plane offset of the column, Q2.14 extended
   localparam int RX_W = 30;   // ray components, Q2.14 extended
   localparam int DL_W = 31;   // delta distances, Q.16
   localparam int SD_W = 40;   // side distances and perpendicular distance
   localparam int LH_W = 20;   // line height

   localparam logic [LH_W-1:0] LH_MAX = 20'hFFFFF;
   localparam logic [21:0]     MAX22  = 22'h3FFFFF;
   localparam logic [22:0]     MAX23  = 23'h7FFFFF;

   // Divider
   localparam int DIV_NUM_W = 31;
   localparam int DIV_DEN_W = 40;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_NUM_W-1:0] ONE_Q30 = 31'h4000_0000;

   typedef struct packed {
      logic       req_type;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic       cell_is_wall;
      logic [9:0] column;
   } gdrc_req_type;

   typedef struct packed {
      logic [22:0] perp_dist;
      logic [1:0]  wall_face;
      logic [5:0]  tex_column;
      logic [8:0]  draw_start;
      logic [8:0]  draw_end;
      logic [21:0] tex_row_start;
      logic [21:0] tex_row_step;
      logic        no_hit;
   } gdrc_rsp_type;

   // response of a cast that meets no wall
   localparam gdrc_rsp_type RSP_NO_HIT = '{no_hit: 1'b1, default: '0};

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } gdrc_div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } gdrc_div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CAMX,
      ST_CAMX_W,
      ST_RAY,
      ST_DX,
      ST_DX_W,
      ST_DY,
      ST_DY_W,
      ST_SIDE,
      ST_WALK,
      ST_LH,
      ST_LH_W,
      ST_STEP,
      ST_STEP_W,
      ST_FIN1,
      ST_FIN2,
      ST_OUT
   } gdrc_state_type;

endpackage

// ----- hw/rtl/gdrc_map_ram.sv -----
// Wall flag memory: one write port, one registered read port, clear sweep after reset.
module gdrc_map_ram import gdrc_pkg::*; #(
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          clear_busy
);

   localparam int DEPTH = 1 << AW;

   logic          mem [DEPTH];
   logic [AW:0]   clr_cnt_ff;
   logic [AW:0]   clr_cnt_in;
   logic          rd_data_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic          wdata;

   // sweep runs until the counter's top bit sets
   assign clear_busy = !clr_cnt_ff[AW];
   assign clr_cnt_in = clear_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   assign we    = clear_busy | wr_en;
   assign waddr = clear_busy ? clr_cnt_ff[AW-1:0] : wr_addr;
   assign wdata = clear_busy ? 1'b0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gdrc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gdrc_div import gdrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  gdrc_div_req_type div_req,
   output gdrc_div_rsp_type div_rsp
);

   localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- hw/rtl/grid_dda_raycast_column.sv -----
// Top level of the grid DDA column ray caster.
// A request either writes one wall flag of the MAP_SIZE x MAP_SIZE grid (no response) or
// casts one screen column and returns one response. A cast runs through a sequencer: the
// column's plane offset and the two delta distances come from a shared restoring divider
// (31 quotient bits per pass), then the DDA walk steps one grid cell per cycle against the
// wall memory (registered read, next cell read issued while the current one is checked),
// then two more divider passes give line height and texture step. The walk steps at most
// MAX_STEPS cells. The response turns valid when the result enters the output register,
// and the next request can be taken in that same cycle; the five divider passes take most
// of a cast's time. A zero ray ends after the first divider pass. Only one request is in
// work at a time; a finished response waits in an output register so the next request can
// start, and a second finished response waits in the sequencer until that register frees.
// After reset the wall memory (2^(2*clog2(MAP_SIZE)) entries, 4096 at the default size) is
// cleared one entry per cycle, and req_stall stays high during that sweep; register writes
// are taken.
// Fixed point: positions Q6.16, vectors Q2.14, distances Q.16.
module grid_dda_raycast_column import gdrc_pkg::*; #(
   parameter int MAP_SIZE  = 64,
   parameter int MAX_STEPS = 128,
   parameter int TEX_SIZE  = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  gdrc_req_type      req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gdrc_rsp_type      rsp_data,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CW     = $clog2(MAP_SIZE);
   localparam int AW     = 2 * CW;
   localparam int CELL_W = (CW > 6) ? CW : 6;
   localparam int MW     = CELL_W + 2;          // signed cell coordinate
   localparam int NW     = $clog2(MAX_STEPS + 1);

   localparam logic signed [MW-1:0] MAP_LIM  = MW'(MAP_SIZE);
   localparam logic signed [MW-1:0] ONE_M    = MW'(1);
   localparam logic [NW-1:0]        STEP_LIM = NW'(MAX_STEPS);
   localparam logic [DIV_NUM_W-1:0] TEX_NUM  = DIV_NUM_W'(TEX_SIZE * 65536);
   localparam logic [8:0]           TEX_MAX  = 9'(TEX_SIZE - 1);
   localparam logic [24:0]          TEX_MUL  = 25'(TEX_SIZE);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [21:0]        cam_x_ff, cam_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [10:0]        screen_w_ff;
   logic [9:0]         screen_h_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff    <= 22'd98304;
         cam_y_ff    <= 22'd98304;
         dir_x_ff    <= 16'sd16384;
         dir_y_ff    <= '0;
         plane_x_ff  <= '0;
         plane_y_ff  <= 16'sd10813;
         screen_w_ff <= 11'd1024;
         screen_h_ff <= 10'd512;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CAM_X:    cam_x_ff    <= csr_pwdata[21:0];
            REG_CAM_Y:    cam_y_ff    <= csr_pwdata[21:0];
            REG_DIR_X:    dir_x_ff    <= signed'(csr_pwdata[15:0]);
            REG_DIR_Y:    dir_y_ff    <= signed'(csr_pwdata[15:0]);
            REG_PLANE_X:  plane_x_ff  <= signed'(csr_pwdata[15:0]);
            REG_PLANE_Y:  plane_y_ff  <= signed'(csr_pwdata[15:0]);
            REG_SCREEN_W: screen_w_ff <= csr_pwdata[10:0];
            REG_SCREEN_H: screen_h_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CAM_X:    csr_prdata = {10'b0, cam_x_ff};
         REG_CAM_Y:    csr_prdata = {10'b0, cam_y_ff};
         REG_DIR_X:    csr_prdata = {16'b0, dir_x_ff};
         REG_DIR_Y:    csr_prdata = {16'b0, dir_y_ff};
         REG_PLANE_X:  csr_prdata = {16'b0, plane_x_ff};
         REG_PLANE_Y:  csr_prdata = {16'b0, plane_y_ff};
         REG_SCREEN_W: csr_prdata = {21'b0, screen_w_ff};
         REG_SCREEN_H: csr_prdata = {22'b0, screen_h_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // width 0 acts as 1, height clamps to 2..512
   logic [10:0] w_eff;
   logic [9:0]  h_cl;
   assign w_eff = (screen_w_ff == '0) ? 11'd1 : screen_w_ff;
   assign h_cl  = (screen_h_ff < 10'd2) ? 10'd2 :
                  (screen_h_ff > 10'd512) ? 10'd512 : screen_h_ff;

   // ------------------------------------------------------------------
   // Submodules
   // ------------------------------------------------------------------
   gdrc_state_type   state_ff, state_in;
   gdrc_div_req_type div_req;
   gdrc_div_rsp_type div_rsp;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [AW-1:0]    mem_raddr;
   logic             rd_wall;
   logic             clear_busy;

   gdrc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gdrc_map_ram #(.AW(AW)) u_map (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (req_data.cell_is_wall),
      .rd_addr    (mem_raddr),
      .rd_data    (rd_wall),
      .clear_busy (clear_busy)
   );

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   logic [9:0]              col_ff;
   logic signed [CX_W-1:0]  cx_ff;
   logic signed [RX_W-1:0]  rx_ff, ry_ff;
   logic [DL_W-1:0]         dx_ff, dy_ff;
   logic [SD_W-1:0]         sx_ff, sy_ff, perp_ff;
   logic signed [MW-1:0]    mx_ff, my_ff;
   logic [NW-1:0]           n_ff;
   logic                    yside_ff;
   logic [LH_W-1:0]         lh_ff;
   logic [8:0]              ds_ff, de_ff;
   logic [21:0]             step_ff;
   logic signed [44:0]      start_prod_ff;
   logic [15:0]             frac_ff;
   gdrc_rsp_type            res_ff;
   gdrc_rsp_type            rsp_ff;
   logic                    rsp_valid_ff;

   logic acc;
   logic out_free;
   assign acc      = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ray signs
   logic rx_neg, ry_neg, infx, infy, zero_ray, rx_pos;
   assign rx_neg   = rx_ff[RX_W-1];
   assign ry_neg   = ry_ff[RX_W-1];
   assign infx     = (rx_ff == '0);
   assign infy     = (ry_ff == '0);
   assign zero_ray = infx && infy;
   assign rx_pos   = !rx_neg && !infx;

   // ray = dir + floor(plane * offset / 2^14)
   logic signed [41:0]     ray_px, ray_py;
   logic signed [RX_W-1:0] rx_in, ry_in;
   assign ray_px = plane_x_ff * cx_ff;
   assign ray_py = plane_y_ff * cx_ff;
   assign rx_in  = RX_W'(ray_px >>> 14) + RX_W'(dir_x_ff);
   assign ry_in  = RX_W'(ray_py >>> 14) + RX_W'(dir_y_ff);

   logic [RX_W-1:0] rx_mag, ry_mag;
   assign rx_mag = rx_neg ? $unsigned(-rx_ff) : $unsigned(rx_ff);
   assign ry_mag = ry_neg ? $unsigned(-ry_ff) : $unsigned(ry_ff);

   // initial side distances
   logic [16:0] fx, fy;
   logic [47:0] side_px, side_py;
   assign fx      = rx_neg ? {1'b0, cam_x_ff[15:0]} : 17'h10000 - {1'b0, cam_x_ff[15:0]};
   assign fy      = ry_neg ? {1'b0, cam_y_ff[15:0]} : 17'h10000 - {1'b0, cam_y_ff[15:0]};
   assign side_px = 48'(fx) * 48'(dx_ff);
   assign side_py = 48'(fy) * 48'(dy_ff);

   // walk step
   logic                 cur_in, take_x, walk_oob, walk_hit, walk_lim;
   logic signed [MW-1:0] nmx, nmy;
   logic [SD_W-1:0]      perp_in;
   assign cur_in   = !mx_ff[MW-1] && !my_ff[MW-1] && (mx_ff < MAP_LIM) && (my_ff < MAP_LIM);
   assign take_x   = !infx && (infy || (sx_ff < sy_ff));
   assign nmx      = rx_neg ? mx_ff - ONE_M : mx_ff + ONE_M;
   assign nmy      = ry_neg ? my_ff - ONE_M : my_ff + ONE_M;
   assign walk_oob = !cur_in;
   assign walk_hit = cur_in && rd_wall;
   assign walk_lim = (n_ff == STEP_LIM);
   // camera inside a wall gives distance zero
   assign perp_in  = (n_ff == '0) ? '0 :
                     yside_ff ? sy_ff - SD_W'(dy_ff) : sx_ff - SD_W'(dx_ff);

   // span
   logic [20:0] lh21, h21, ds_raw, de_raw;
   logic [8:0]  ds_in, de_in;
   assign lh21   = 21'(lh_ff);
   assign h21    = 21'(h_cl);
   assign ds_raw = (h21 > lh21) ? (h21 - lh21) >> 1 : '0;
   assign de_raw = (h21 + lh21) >> 1;
   assign ds_in  = (ds_raw > h21 - 21'd1) ? 9'(h21 - 21'd1) : ds_raw[8:0];
   assign de_in  = (de_raw > h21 - 21'd1) ? 9'(h21 - 21'd1) : de_raw[8:0];

   // texture row start
   logic signed [21:0] row_off;
   logic signed [44:0] start_prod_in, start_sh;
   logic [21:0]        start_cl;
   assign row_off       = signed'(22'({ds_ff, 1'b0})) + signed'(22'(lh_ff)) -
                          signed'(22'(h_cl));
   assign start_prod_in = row_off * signed'({1'b0, step_ff});
   assign start_sh      = start_prod_ff >>> 1;
   assign start_cl      = start_sh[44] ? '0 :
                          (start_sh > 45'sd4194303) ? MAX22 : start_sh[21:0];

   // texture column: only the low 16 bits of the hit coordinate matter
   logic [29:0] hit_mul, frac_p;
   logic [15:0] frac_in, hit_base;
   logic [24:0] tex_p;
   logic [8:0]  tex_raw, tex_fl;
   logic        flip;
   assign hit_mul  = yside_ff ? $unsigned(rx_ff) : $unsigned(ry_ff);
   assign hit_base = yside_ff ? cam_x_ff[15:0] : cam_y_ff[15:0];
   assign frac_p   = perp_ff[29:0] * hit_mul;
   assign frac_in  = hit_base + frac_p[29:14];
   assign tex_p    = 25'(frac_ff) * TEX_MUL;
   assign tex_raw  = tex_p[24:16];
   assign flip     = yside_ff ? ry_neg : rx_pos;
   assign tex_fl   = flip ? TEX_MAX - tex_raw : tex_raw;

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (acc && req_data.req_type == REQ_CAST) state_in = ST_CAMX;
         ST_CAMX:   state_in = ST_CAMX_W;
         ST_CAMX_W: if (div_rsp.done) state_in = ST_RAY;
         ST_RAY:    state_in = ST_DX;
         ST_DX:     state_in = zero_ray ? ST_OUT : ST_DX_W;
         ST_DX_W:   if (div_rsp.done) state_in = ST_DY;
         ST_DY:     state_in = ST_DY_W;
         ST_DY_W:   if (div_rsp.done) state_in = ST_SIDE;
         ST_SIDE:   state_in = ST_WALK;
         ST_WALK: begin
            if (walk_oob) state_in = ST_OUT;
            else if (walk_hit) state_in = ST_LH;
            else if (walk_lim) state_in = ST_OUT;
         end
         ST_LH:     state_in = ST_LH_W;
         ST_LH_W:   if (div_rsp.done) state_in = ST_STEP;
         ST_STEP:   state_in = ST_STEP_W;
         ST_STEP_W: if (div_rsp.done) state_in = ST_FIN1;
         ST_FIN1:   state_in = ST_FIN2;
         ST_FIN2:   state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------
   logic [CELL_W-1:0] wcx, wcy;
   assign wcx = CELL_W'(req_data.cell_x);
   assign wcy = CELL_W'(req_data.cell_y);

   always_comb begin
      req_stall        = (state_ff != ST_IDLE) || clear_busy;
      mem_we           = acc && (req_data.req_type == REQ_WRITE) &&
                         (int'(req_data.cell_x) < MAP_SIZE) &&
                         (int'(req_data.cell_y) < MAP_SIZE);
      mem_waddr        = {wcy[CW-1:0], wcx[CW-1:0]};
      mem_raddr        = {my_ff[CW-1:0], mx_ff[CW-1:0]};
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         ST_CAMX: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'({col_ff, 15'b0});
            div_req.divisor  = DIV_DEN_W'(w_eff);
         end
         ST_DX: begin
            div_req.start    = !zero_ray;
            div_req.dividend = ONE_Q30;
            div_req.divisor  = DIV_DEN_W'(rx_mag);
         end
         ST_DY: begin
            div_req.start    = 1'b1;
            div_req.dividend = ONE_Q30;
            div_req.divisor  = DIV_DEN_W'(ry_mag);
         end
         ST_WALK: begin
            // fetch the next cell while this one is checked
            mem_raddr = take_x ? {my_ff[CW-1:0], nmx[CW-1:0]} : {nmy[CW-1:0], mx_ff[CW-1:0]};
         end
         ST_LH: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'({h_cl, 16'b0});
            div_req.divisor  = perp_ff;
         end
         ST_STEP: begin
            div_req.start    = 1'b1;
            div_req.dividend = TEX_NUM;
            div_req.divisor  = DIV_DEN_W'(lh_ff);
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath updates
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            col_ff <= req_data.column;
            mx_ff  <= signed'(MW'(cam_x_ff[21:16]));
            my_ff  <= signed'(MW'(cam_y_ff[21:16]));
         end
         ST_CAMX_W: begin
            cx_ff <= signed'({1'b0, div_rsp.quotient[24:0]}) - 26'sd16384;
         end
         ST_RAY: begin
            rx_ff <= rx_in;
            ry_ff <= ry_in;
         end
         ST_DX: begin
            // zero ray: nothing to hit
            res_ff <= RSP_NO_HIT;
         end
         ST_DX_W: if (div_rsp.done) dx_ff <= infx ? '0 : div_rsp.quotient;
         ST_DY_W: if (div_rsp.done) dy_ff <= infy ? '0 : div_rsp.quotient;
         ST_SIDE: begin
            sx_ff    <= SD_W'(side_px[47:16]);
            sy_ff    <= SD_W'(side_py[47:16]);
            n_ff     <= '0;
            yside_ff <= 1'b0;
         end
         ST_WALK: begin
            perp_ff <= perp_in;
            res_ff  <= RSP_NO_HIT;
            if (!walk_oob && !walk_hit && !walk_lim) begin
               n_ff <= n_ff + 1'b1;
               if (take_x) begin
                  sx_ff    <= sx_ff + SD_W'(dx_ff);
                  mx_ff    <= nmx;
                  yside_ff <= 1'b0;
               end else begin
                  sy_ff    <= sy_ff + SD_W'(dy_ff);
                  my_ff    <= nmy;
                  yside_ff <= 1'b1;
               end
            end
         end
         ST_LH_W: begin
            if (div_rsp.done) begin
               if (perp_ff == '0 || div_rsp.quotient > DIV_NUM_W'(LH_MAX)) lh_ff <= LH_MAX;
               else lh_ff <= div_rsp.quotient[LH_W-1:0];
            end
         end
         ST_STEP: begin
            ds_ff <= ds_in;
            de_ff <= de_in;
         end
         ST_STEP_W: begin
            if (div_rsp.done) begin
               if (lh_ff == '0 || div_rsp.quotient > DIV_NUM_W'(MAX22)) step_ff <= MAX22;
               else step_ff <= div_rsp.quotient[21:0];
            end
         end
         ST_FIN1: begin
            start_prod_ff <= start_prod_in;
            frac_ff       <= frac_in;
         end
         ST_FIN2: begin
            res_ff.perp_dist     <= (perp_ff > SD_W'(MAX23)) ? MAX23 : perp_ff[22:0];
            res_ff.wall_face     <= yside_ff ? (ry_neg ? FACE_NORTH : FACE_SOUTH) :
                                               (rx_neg ? FACE_WEST : FACE_EAST);
            res_ff.tex_column    <= tex_fl[5:0];
            res_ff.draw_start    <= ds_ff;
            res_ff.draw_end      <= de_ff;
            res_ff.tex_row_start <= start_cl;
            res_ff.tex_row_step  <= step_ff;
            res_ff.no_hit        <= 1'b0;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> req_stall)
      else $error("request taken during map clear");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (n_ff <= STEP_LIM))
      else $error("walk ran past the step limit");

   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.no_hit) |->
         (rsp_data.perp_dist == '0 && rsp_data.tex_row_step == '0))
      else $error("no-hit response carries data");

endmodule

// ----- dv/tb_grid_dda_raycast_column.sv -----
// Testbench of the grid DDA column ray caster: random and directed requests against a predictor.
module tb_grid_dda_raycast_column import gdrc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID = 64;
   localparam int TEX  = 64;
   localparam int WALK_LIMIT = 128;
   localparam int SETTLE_CYCLES = 400;  // > one full cast
   localparam int REQ_W = $bits(gdrc_req_type);

   // Scoreboard: own copy of the wall grid and registers, queue of predicted casts.
   class raycast_scoreboard;
      bit                 walls [0:GRID*GRID-1];
      logic [21:0]        cam_x, cam_y;
      logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
      logic [10:0]        scr_w;
      logic [9:0]         scr_h;
      gdrc_rsp_type       casts_due [$];
      int                 errors;

      function new();
         foreach (walls[i]) walls[i] = 0;
         cam_x = 98304; cam_y = 98304;
         dir_x = 16384; dir_y = 0;
         plane_x = 0; plane_y = 10813;
         scr_w = 1024; scr_h = 512;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_CAM_X:    cam_x   = v[21:0];
            REG_CAM_Y:    cam_y   = v[21:0];
            REG_DIR_X:    dir_x   = v[15:0];
            REG_DIR_Y:    dir_y   = v[15:0];
            REG_PLANE_X:  plane_x = v[15:0];
            REG_PLANE_Y:  plane_y = v[15:0];
            REG_SCREEN_W: scr_w   = v[10:0];
            REG_SCREEN_H: scr_h   = v[9:0];
            default: ;
         endcase
      endfunction

      function bit wall_at(longint x, longint y);
         return walls[y * GRID + x];
      endfunction

      function bit on_grid(longint x, longint y);
         return x >= 0 && y >= 0 && x < GRID && y < GRID;
      endfunction

      // One column cast, all floors toward minus infinity (>>> on signed longint).
      function gdrc_rsp_type cast_column(logic [9:0] column);
         longint w, h, col, cx, rx, ry, px, py, mx, my, dx, dy, stx, sty;
         longint fx, fy, sx, sy, perp, lh, ds, de, stp, st, hitc, frac, tex;
         bit infx, infy, yside, hit;
         gdrc_rsp_type r;
         r = '0;
         w = (scr_w == 0) ? 1 : scr_w;
         h = scr_h;
         if (h < 2) h = 2;
         if (h > 512) h = 512;
         col = column;
         cx = ((col << 15) / w) - 16384;
         rx = longint'(dir_x) + ((longint'(plane_x) * cx) >>> 14);
         ry = longint'(dir_y) + ((longint'(plane_y) * cx) >>> 14);
         px = cam_x; py = cam_y;
         mx = px >> 16; my = py >> 16;
         if ((rx == 0 && ry == 0) || !on_grid(mx, my)) begin
            r.no_hit = 1;
            return r;
         end
         infx = (rx == 0); infy = (ry == 0);
         dx = infx ? 0 : (64'sd1 << 30) / (rx < 0 ? -rx : rx);
         dy = infy ? 0 : (64'sd1 << 30) / (ry < 0 ? -ry : ry);
         stx = rx < 0 ? -1 : 1;
         sty = ry < 0 ? -1 : 1;
         fx = rx < 0 ? px - (mx << 16) : ((mx + 1) << 16) - px;
         fy = ry < 0 ? py - (my << 16) : ((my + 1) << 16) - py;
         sx = (fx * dx) >>> 16;
         sy = (fy * dy) >>> 16;
         yside = 0;
         perp = 0;
         if (!wall_at(mx, my)) begin
            hit = 0;
            for (int n = 0; n < WALK_LIMIT; n++) begin
               if (!infx && (infy || sx < sy)) begin
                  sx += dx; mx += stx; yside = 0;
               end else begin
                  sy += dy; my += sty; yside = 1;
               end
               if (!on_grid(mx, my)) break;
               if (wall_at(mx, my)) begin
                  hit = 1;
                  break;
               end
            end
            if (!hit) begin
               r.no_hit = 1;
               return r;
            end
            perp = yside ? sy - dy : sx - dx;
            if (perp < 0) perp = 0;
         end
         lh = (perp == 0) ? LH_MAX : (h << 16) / perp;
         if (lh > LH_MAX) lh = LH_MAX;
         ds = (h > lh) ? (h - lh) >> 1 : 0;
         de = (h + lh) >> 1;
         if (ds > h - 1) ds = h - 1;
         if (de > h - 1) de = h - 1;
         stp = (lh == 0) ? MAX22 : (longint'(TEX) << 16) / lh;
         if (stp > MAX22) stp = MAX22;
         st = ((2 * ds + lh - h) * stp) >>> 1;
         if (st < 0) st = 0;
         if (st > MAX22) st = MAX22;
         hitc = yside ? px + ((perp * rx) >>> 14) : py + ((perp * ry) >>> 14);
         frac = hitc & 64'hFFFF;
         tex = (frac * TEX) >> 16;
         if ((!yside && rx > 0) || (yside && ry < 0)) tex = TEX - 1 - tex;
         r.perp_dist     = (perp > MAX23) ? MAX23 : perp[22:0];
         r.wall_face     = yside ? ((sty == 1) ? FACE_SOUTH : FACE_NORTH)
                                 : ((stx == 1) ? FACE_EAST : FACE_WEST);
         r.tex_column    = tex[5:0];
         r.draw_start    = ds[8:0];
         r.draw_end      = de[8:0];
         r.tex_row_start = st[21:0];
         r.tex_row_step  = stp[21:0];
         r.no_hit        = 0;
         return r;
      endfunction

      // Accepted request: a write updates the grid, a cast queues its prediction.
      function void note_request(gdrc_req_type q);
         if (q.req_type == REQ_WRITE) walls[q.cell_y * GRID + q.cell_x] = q.cell_is_wall;
         else casts_due.push_back(cast_column(q.column));
      endfunction

      function void field_check(string name, longint e, longint a);
         if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(gdrc_rsp_type a);
         gdrc_rsp_type e;
         if (casts_due.size() == 0) begin
            $display("%0t unexpected response: expected none actual %h", $realtime, a);
            errors++;
            return;
         end
         e = casts_due.pop_front();
         field_check("perp_dist", e.perp_dist, a.perp_dist);
         field_check("wall_face", e.wall_face, a.wall_face);
         field_check("tex_column", e.tex_column, a.tex_column);
         field_check("draw_start", e.draw_start, a.draw_start);
         field_check("draw_end", e.draw_end, a.draw_end);
         field_check("tex_row_start", e.tex_row_start, a.tex_row_start);
         field_check("tex_row_step", e.tex_row_step, a.tex_row_step);
         field_check("no_hit", e.no_hit, a.no_hit);
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   gdrc_req_type      req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   gdrc_rsp_type      rsp_data;
   logic              csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   raycast_scoreboard sb = new();

   // Idle percentages for the current phase; hold_off is a long receiver stall.
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_off  = 0;

   grid_dda_raycast_column dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Receiver: check at the rising edge, choose the next stall at the falling edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Run limit, far beyond the slowest legal run (clear sweep plus ~600 slow casts).
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // One request: offered at the falling edge, held until taken.
   task automatic send_request(gdrc_req_type q);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
   endtask

   task automatic write_cell(int x, int y, bit wall);
      gdrc_req_type q;
      q = gdrc_req_type'(REQ_W'($urandom));
      q.req_type = REQ_WRITE;
      q.cell_x = 6'(x); q.cell_y = 6'(y); q.cell_is_wall = wall;
      send_request(q);
   endtask

   task automatic cast(int column);
      gdrc_req_type q;
      q = gdrc_req_type'(REQ_W'($urandom));
      q.req_type = REQ_CAST;
      q.column = 10'(column);
      send_request(q);
   endtask

   // Wait for every predicted response, then let any trailing write finish.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.casts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high.
   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // Random request: mostly casts and writes near the camera so rays hit walls.
   task automatic random_request();
      gdrc_req_type q;
      int r, x, y, w;
      q = gdrc_req_type'(REQ_W'($urandom));
      r = $urandom_range(0, 99);
      if (r < 30) begin
         x = int'(sb.cam_x[21:16]) + $urandom_range(0, 8) - 4;
         y = int'(sb.cam_y[21:16]) + $urandom_range(0, 8) - 4;
         q.req_type = REQ_WRITE;
         if (x >= 0 && x < GRID) q.cell_x = 6'(x);
         if (y >= 0 && y < GRID) q.cell_y = 6'(y);
      end else if (r < 36) begin
         q.req_type = REQ_WRITE;   // anywhere, fully random
      end else begin
         q.req_type = REQ_CAST;
         w = (sb.scr_w == 0) ? 1 : ((sb.scr_w > 1024) ? 1024 : int'(sb.scr_w));
         if ($urandom_range(0, 9) != 0) q.column = 10'($urandom_range(0, w - 1));
      end
      send_request(q);
   endtask

   task automatic load_phase(int p);
      logic [31:0] v [8];
      v[0] = $urandom_range(0, 4194303);
      v[1] = $urandom_range(0, 4194303);
      v[2] = $urandom; v[3] = $urandom; v[4] = $urandom; v[5] = $urandom;
      v[6] = 1024; v[7] = 512;
      case (p)
         2: begin v[6] = 1; v[7] = 2; end
         3: begin v[6] = 0; v[7] = 0; end
         4: begin v[2] = 0; v[3] = 0; v[4] = 0; v[5] = 0; v[6] = 2047; v[7] = 1023; end
         5: begin
            v[0] = 0; v[1] = 0;
            v[2] = 32'h7FFF; v[3] = 32'h8000; v[4] = 32'h8000; v[5] = 32'h7FFF;
            v[6] = 640; v[7] = 480;
         end
         6: begin v[0] = 4194303; v[1] = 4194303; v[6] = 1; v[7] = 1; end
         7: begin
            v[0] = 98304; v[1] = 98304; v[2] = 16384; v[3] = 0;
            v[4] = 0; v[5] = 10813;
         end
         8: begin v[6] = $urandom_range(0, 2047); v[7] = $urandom_range(0, 1023); end
         default: ;
      endcase
      for (int i = 0; i < 8; i++) csr_write(3'(i), v[i]);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part at reset settings: camera in cell (1,1) looking +x.
      cast(0);                 // empty grid: ray leaves the grid
      cast(512);               // zero y component of the ray
      cast(1023);
      write_cell(1, 1, 1);     // camera inside a wall
      cast(300);
      write_cell(1, 1, 0);
      write_cell(4, 1, 1);
      write_cell(1, 4, 1);
      write_cell(1, 0, 1);
      cast(512);
      cast(0);
      cast(1023);
      cast(700);
      write_cell(2, 1, 1);     // adjacent wall: short distance, tall span
      cast(512);
      write_cell(63, 63, 1);
      write_cell(0, 63, 1);
      write_cell(63, 0, 0);
      write_cell(2, 1, 0);
      cast(100);
      drain();

      for (int p = 1; p <= 8; p++) begin
         load_phase(p);
         idle_pct  = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 7 : 59) : 0;
         stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 7 : 59) : 0;
         if (p == 2) begin
            idle_pct = 0;
            hold_off = 3000;   // receiver holds off while requests keep coming
         end
         for (int n = 0; n < 75; n++) begin
            random_request();
            if (p == 5 && n == 37) drain();   // sender pauses until all responses are in
         end
         drain();
      end

      if (sb.casts_due.size() != 0) begin
         $display("%0t missing responses: %0d", $realtime, sb.casts_due.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/gdrc_pkg.sv
hw/rtl/gdrc_map_ram.sv
hw/rtl/gdrc_div.sv
hw/rtl/grid_dda_raycast_column.sv
dv/tb_grid_dda_raycast_column.sv
